// ----- rtl/core/fxfft_pkg.sv -----
// Shared types, constants and the twiddle ROM generator for the fixed-point FFT.
package fxfft_pkg;

  localparam int unsigned STORE_LOG2     = 10;
  localparam int unsigned STORE_LEN      = 1 << STORE_LOG2;
  localparam int unsigned IDX_W          = STORE_LOG2;
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned ENTRY_W        = 2 * DATA_W;
  localparam int unsigned TABLE_LOG2_DEF = 10;
  localparam int unsigned SIZE_W         = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] SINE_AMPL   = 64'd32767;

  // Item actions
  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_XFORM  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  // Result kinds
  typedef enum logic [0:0] {
    KIND_BIN  = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  // Sources for the store write port
  typedef enum logic [2:0] {
    WSRC_INPUT,
    WSRC_A,
    WSRC_B,
    WSRC_SUM,
    WSRC_DIFF
  } wsrc_e;

  // Operand pairs for the shared multiplier
  typedef enum logic [1:0] {
    MUL_RR,
    MUL_II,
    MUL_RI,
    MUL_IR
  } mul_e;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_LOAD,
    S_BR_CHK,
    S_BR_RA,
    S_BR_RB,
    S_BR_LB,
    S_BR_WM,
    S_BR_WR,
    S_BF_RH,
    S_BF_RI,
    S_BF_M0,
    S_BF_M1,
    S_BF_M2,
    S_BF_M3,
    S_BF_T,
    S_BF_WH,
    S_BF_WI,
    S_DONE
  } state_e;

  // Commands from sequencer to datapath
  typedef struct packed {
    logic [IDX_W-1:0] raddr;
    logic             ld_a;
    logic             ld_b;
    logic             ld_wr;
    logic             ld_wi;
    logic             mul_en;
    mul_e             mul_sel;
    logic             ld_t;
    logic             ram_we;
    logic [IDX_W-1:0] waddr;
    wsrc_e            wsrc;
    logic             out_load;
    kind_e            out_kind;
    logic [IDX_W-1:0] out_index;
  } cmd_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic out_valid;
  } stat_t;

  // Q62 multiply, keeps bits 125:62 of the full product
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Divide a series term by k*(k+1) for the given step
  function automatic logic [63:0] div_kk(logic [63:0] t, int unsigned n, logic want_sin);
    logic [63:0] res;
    case (n)
      0:       res = want_sin ? t / 64'd6   : t / 64'd2;
      1:       res = want_sin ? t / 64'd20  : t / 64'd12;
      2:       res = want_sin ? t / 64'd42  : t / 64'd30;
      3:       res = want_sin ? t / 64'd72  : t / 64'd56;
      4:       res = want_sin ? t / 64'd110 : t / 64'd90;
      5:       res = want_sin ? t / 64'd156 : t / 64'd132;
      6:       res = want_sin ? t / 64'd210 : t / 64'd182;
      7:       res = want_sin ? t / 64'd272 : t / 64'd240;
      8:       res = want_sin ? t / 64'd342 : t / 64'd306;
      9:       res = want_sin ? t / 64'd420 : t / 64'd380;
      10:      res = want_sin ? t / 64'd506 : t / 64'd462;
      11:      res = want_sin ? t / 64'd600 : t / 64'd552;
      default: res = want_sin ? t / 64'd702 : t / 64'd650;
    endcase
    return res;
  endfunction

  // Taylor series in Q62 for 0 <= x <= pi/4
  function automatic logic [63:0] series(logic [63:0] x, logic want_sin);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic        sub;
    x2   = mul_q62(x, x);
    term = want_sin ? x : ONE_Q62;
    sum  = term;
    sub  = 1'b1;
    for (int unsigned n = 0; n < 13; n++) begin
      term = div_kk(mul_q62(term, x2), n, want_sin);
      sum  = sub ? sum - term : sum + term;
      sub  = !sub;
    end
    return sum;
  endfunction

  // round(32767 * sin(pi/2 * m / 2^qlog))
  function automatic logic [15:0] quarter_sine(logic [63:0] m, int unsigned qlog);
    logic [63:0] q;
    logic [63:0] a;
    logic [63:0] frac;
    logic [63:0] s;
    logic [63:0] r;
    logic        use_sin;
    q       = 64'd1 << qlog;
    use_sin = ((m << 1) <= q);
    a       = use_sin ? m : q - m;
    frac    = a << (62 - qlog);
    s       = series(mul_q62(HALF_PI_Q62, frac), use_sin);
    r       = (s >> 15) * SINE_AMPL;
    r       = (r + (64'd1 << 46)) >> 47;
    return r[15:0];
  endfunction

  // Sine ROM entry i for a table of 2^tlog points per turn
  function automatic logic signed [15:0] rom_value(int unsigned tlog, int unsigned idx);
    int unsigned qlog;
    int unsigned quad;
    logic [63:0] q;
    logic [63:0] r;
    logic [15:0] v;
    qlog = tlog - 2;
    q    = 64'd1 << qlog;
    quad = idx >> qlog;
    r    = 64'(idx) & (q - 64'd1);
    if (quad == 0) begin
      v = quarter_sine(r, qlog);
    end else if (quad == 1) begin
      v = quarter_sine(q - r, qlog);
    end else begin
      v = -quarter_sine(r, qlog);
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/fxfft_if.sv -----
// Item channel interfaces: sample/command input and result output.
interface fxfft_in_if;
  import fxfft_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [IDX_W-1:0]         sample_index;
  logic signed [DATA_W-1:0] sample_real;
  logic signed [DATA_W-1:0] sample_imag;

  modport source (output valid, action, sample_index, sample_real, sample_imag,
                  input ready);
  modport sink   (input valid, action, sample_index, sample_real, sample_imag,
                  output ready);
endinterface

interface fxfft_out_if;
  import fxfft_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [IDX_W-1:0]         bin_index;
  logic signed [DATA_W-1:0] bin_real;
  logic signed [DATA_W-1:0] bin_imag;

  modport source (output valid, result_kind, bin_index, bin_real, bin_imag,
                  input ready);
  modport sink   (input valid, result_kind, bin_index, bin_real, bin_imag,
                  output ready);
endinterface

// ----- rtl/core/fixed_point_complex_fft.sv -----
// Top level of the in-place 16-bit radix-2 fixed-point complex FFT.
// Items on in_i write one sample, read one bin (result on out_o) or run a
// transform of 2^size_log2 points and answer with a done item. A transform
// checks each index for a bit-reversed partner, swaps each pair (S_BR_RA to
// S_BR_WR), runs the butterflies (S_BF_RH to S_BF_WI) and posts the done item,
// which an invalid length posts at once; the single read port of the sample
// store and the one shared multiplier (four products per butterfly) pace this.
// Writes are taken while a result waits on out_o; reads and transforms wait for
// the result register. The sample store holds garbage after reset until written.
module fixed_point_complex_fft #(
  parameter int unsigned TABLE_LOG2 = fxfft_pkg::TABLE_LOG2_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fxfft_pkg::SIZE_W-1:0]  cfg_wdata_i,
  fxfft_in_if.sink                      in_i,
  fxfft_out_if.source                   out_o
);
  import fxfft_pkg::*;

  cmd_t                  cmd;
  stat_t                 stat;
  logic [TABLE_LOG2-1:0] tw_addr;

  fxfft_ctrl #(
    .TABLE_LOG2 (TABLE_LOG2)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_index_i  (in_i.sample_index),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .tw_addr_o   (tw_addr)
  );

  fxfft_dp #(
    .TABLE_LOG2 (TABLE_LOG2)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .tw_addr_i     (tw_addr),
    .sample_real_i (in_i.sample_real),
    .sample_imag_i (in_i.sample_imag),
    .stat_o        (stat),
    .out_o         (out_o)
  );
endmodule

// ----- rtl/core/fxfft_ram.sv -----
// Generic simple dual-port RAM with registered read.
module fxfft_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/fxfft_dp.sv -----
// FFT datapath: sample store, twiddle ROM, butterfly arithmetic, result register.
module fxfft_dp #(
  parameter int unsigned TABLE_LOG2 = fxfft_pkg::TABLE_LOG2_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fxfft_pkg::cmd_t                        cmd_i,
  input  logic [TABLE_LOG2-1:0]                  tw_addr_i,
  input  logic signed [fxfft_pkg::DATA_W-1:0]    sample_real_i,
  input  logic signed [fxfft_pkg::DATA_W-1:0]    sample_imag_i,
  output fxfft_pkg::stat_t                       stat_o,
  fxfft_out_if.source                            out_o
);
  import fxfft_pkg::*;

  localparam int unsigned RomLen = (3 << TABLE_LOG2) >> 2;

  logic signed [DATA_W-1:0] rom_tab [RomLen];
  logic signed [DATA_W-1:0] tw_q;

  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] a_q;
  logic [ENTRY_W-1:0] b_q;

  logic signed [DATA_W-1:0] wr_q, wi_q;
  logic signed [DATA_W:0]   tw_neg;
  logic signed [DATA_W-1:0] op_x, op_y;
  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W+1:0]        prod_sh;
  logic [DATA_W-1:0]        fm;
  logic signed [DATA_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [DATA_W-1:0] tr_q, ti_q;
  logic signed [DATA_W-1:0] qr, qi;
  logic signed [DATA_W-1:0] sum_re, sum_im, dif_re, dif_im;

  logic                     out_valid_q;
  logic                     out_kind_q;
  logic [IDX_W-1:0]         out_index_q;
  logic signed [DATA_W-1:0] out_re_q, out_im_q;

  // Constant sine table
  for (genvar g = 0; g < RomLen; g++) begin : g_rom
    localparam logic signed [DATA_W-1:0] RomVal = rom_value(TABLE_LOG2, g);
    assign rom_tab[g] = RomVal;
  end

  always_ff @(posedge clk_i) begin
    tw_q <= rom_tab[tw_addr_i];
  end

  // Store write source select
  always_comb begin
    case (cmd_i.wsrc)
      WSRC_INPUT: wdata = {sample_real_i, sample_imag_i};
      WSRC_A:     wdata = a_q;
      WSRC_B:     wdata = b_q;
      WSRC_SUM:   wdata = {sum_re, sum_im};
      WSRC_DIFF:  wdata = {dif_re, dif_im};
      default:    wdata = {sample_real_i, sample_imag_i};
    endcase
  end

  fxfft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (cmd_i.waddr),
    .wdata_i (wdata),
    .raddr_i (cmd_i.raddr),
    .rdata_o (rdata)
  );

  // Operand and halved twiddle registers
  assign tw_neg = -{tw_q[DATA_W-1], tw_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      a_q <= rdata;
    end
    if (cmd_i.ld_b) begin
      b_q <= rdata;
    end
    if (cmd_i.ld_wr) begin
      wr_q <= {tw_q[DATA_W-1], tw_q[DATA_W-1:1]};
    end
    if (cmd_i.ld_wi) begin
      wi_q <= tw_neg[DATA_W:1];
    end
  end

  // Shared rounded Q15 multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RR:  begin op_x = wr_q; op_y = a_q[ENTRY_W-1:DATA_W]; end
      MUL_II:  begin op_x = wi_q; op_y = a_q[DATA_W-1:0];       end
      MUL_RI:  begin op_x = wr_q; op_y = a_q[DATA_W-1:0];       end
      MUL_IR:  begin op_x = wi_q; op_y = a_q[ENTRY_W-1:DATA_W]; end
      default: begin op_x = wr_q; op_y = a_q[ENTRY_W-1:DATA_W]; end
    endcase
  end

  assign prod    = op_x * op_y;
  assign prod_sh = prod[2*DATA_W-1:DATA_W-2];
  assign fm      = prod_sh[DATA_W:1] + {{(DATA_W-1){1'b0}}, prod_sh[0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_RR:  p_rr_q <= fm;
        MUL_II:  p_ii_q <= fm;
        MUL_RI:  p_ri_q <= fm;
        MUL_IR:  p_ir_q <= fm;
        default: p_rr_q <= fm;
      endcase
    end
    if (cmd_i.ld_t) begin
      tr_q <= p_rr_q - p_ii_q;
      ti_q <= p_ri_q + p_ir_q;
    end
  end

  // Butterfly outputs, lower operand halved
  assign qr     = {b_q[ENTRY_W-1], b_q[ENTRY_W-1:DATA_W+1]};
  assign qi     = {b_q[DATA_W-1], b_q[DATA_W-1:1]};
  assign sum_re = qr + tr_q;
  assign sum_im = qi + ti_q;
  assign dif_re = qr - tr_q;
  assign dif_im = qi - ti_q;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q  <= cmd_i.out_kind;
      out_index_q <= cmd_i.out_index;
      if (cmd_i.out_kind == KIND_DONE) begin
        out_re_q <= '0;
        out_im_q <= '0;
      end else begin
        out_re_q <= rdata[ENTRY_W-1:DATA_W];
        out_im_q <= rdata[DATA_W-1:0];
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.bin_index   = out_index_q;
  assign out_o.bin_real    = out_re_q;
  assign out_o.bin_imag    = out_im_q;
  assign stat_o.out_valid  = out_valid_q;

  // A new result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten");
endmodule

// ----- rtl/core/fxfft_ctrl.sv -----
// FFT sequencer: item intake, bit-reverse pass and butterfly schedule.
module fxfft_ctrl #(
  parameter int unsigned TABLE_LOG2 = fxfft_pkg::TABLE_LOG2_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fxfft_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic [1:0]                     in_action_i,
  input  logic [fxfft_pkg::IDX_W-1:0]    in_index_i,
  output logic                           in_ready_o,
  input  logic                           out_ready_i,
  input  fxfft_pkg::stat_t               stat_i,
  output fxfft_pkg::cmd_t                cmd_o,
  output logic [TABLE_LOG2-1:0]          tw_addr_o
);
  import fxfft_pkg::*;

  localparam int unsigned RA = TABLE_LOG2;
  localparam int unsigned KW = $clog2(TABLE_LOG2);
  localparam logic [RA-1:0] QuarterOff = RA'(1 << (TABLE_LOG2 - 2));

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W:0]    m_q, m_d;
  logic [IDX_W-1:0]  i_q, i_d;
  logic [SIZE_W-1:0] st_q, st_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic [IDX_W:0]    n_len;
  logic [IDX_W:0]    l_len;
  logic [IDX_W-1:0]  rv;
  logic [IDX_W-1:0]  rev;
  logic [IDX_W-1:0]  h_idx;
  logic [IDX_W+1:0]  i_step;
  logic [IDX_W:0]    m_inc;
  logic [KW-1:0]     k_sh;
  logic [RA+IDX_W-1:0] mk;
  logic [RA-1:0]     j_idx;
  logic              size_ok;
  logic              fire;

  // Loop bounds and indexes
  assign n_len  = (IDX_W+1)'(1) << size_q;
  assign l_len  = (IDX_W+1)'(1) << st_q;
  assign h_idx  = i_q + l_len[IDX_W-1:0];
  assign i_step = (IDX_W+2)'(i_q) + {l_len, 1'b0};
  assign m_inc  = m_q + 1'b1;
  assign k_sh   = KW'(TABLE_LOG2 - 1) - KW'(st_q);
  assign mk     = {{RA{1'b0}}, m_q[IDX_W-1:0]} << k_sh;
  assign j_idx  = mk[RA-1:0];
  assign size_ok = (size_q != '0) && (32'(size_q) <= TABLE_LOG2)
                && (32'(size_q) <= STORE_LOG2);

  // Bit-reversed partner of m within the active length
  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      rv[IDX_W-1-b] = m_q[b];
    end
    rev = rv >> (SIZE_W'(STORE_LOG2) - size_q);
  end

  // Input handshake: result-producing items wait for a free result register
  always_comb begin
    case (action_e'(in_action_i))
      ACT_READ, ACT_XFORM: in_ready_o = (state_q == S_IDLE)
                                     && (!stat_i.out_valid || out_ready_i);
      default:             in_ready_o = (state_q == S_IDLE);
    endcase
  end
  assign fire = in_valid_i && in_ready_o;

  // Twiddle address: cosine leg first, then sine leg
  assign tw_addr_o = (state_q == S_BF_RH) ? j_idx + QuarterOff : j_idx;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    i_d     = i_q;
    st_d    = st_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (fire) begin
          case (action_e'(in_action_i))
            ACT_WRITE: begin
              cmd_o.ram_we = 1'b1;
              cmd_o.waddr  = in_index_i;
              cmd_o.wsrc   = WSRC_INPUT;
            end
            ACT_READ: begin
              idx_d   = in_index_i;
              state_d = S_RD_ISSUE;
            end
            ACT_XFORM: begin
              m_d     = (IDX_W+1)'(1);
              state_d = size_ok ? S_BR_CHK : S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_RD_ISSUE: begin
        cmd_o.raddr = idx_q;
        state_d     = S_RD_LOAD;
      end
      S_RD_LOAD: begin
        cmd_o.out_load  = 1'b1;
        cmd_o.out_kind  = KIND_BIN;
        cmd_o.out_index = idx_q;
        state_d         = S_IDLE;
      end
      // Bit-reverse pass
      S_BR_CHK: begin
        if (m_q == n_len) begin
          st_d    = '0;
          m_d     = '0;
          i_d     = '0;
          state_d = S_BF_RH;
        end else if (rev > m_q[IDX_W-1:0]) begin
          state_d = S_BR_RA;
        end else begin
          m_d = m_inc;
        end
      end
      S_BR_RA: begin
        cmd_o.raddr = m_q[IDX_W-1:0];
        state_d     = S_BR_RB;
      end
      S_BR_RB: begin
        cmd_o.raddr = rev;
        cmd_o.ld_a  = 1'b1;
        state_d     = S_BR_LB;
      end
      S_BR_LB: begin
        cmd_o.ld_b = 1'b1;
        state_d    = S_BR_WM;
      end
      S_BR_WM: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.waddr  = m_q[IDX_W-1:0];
        cmd_o.wsrc   = WSRC_B;
        state_d      = S_BR_WR;
      end
      S_BR_WR: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.waddr  = rev;
        cmd_o.wsrc   = WSRC_A;
        m_d          = m_inc;
        state_d      = S_BR_CHK;
      end
      // Butterflies
      S_BF_RH: begin
        cmd_o.raddr = h_idx;
        state_d     = S_BF_RI;
      end
      S_BF_RI: begin
        cmd_o.raddr = i_q;
        cmd_o.ld_a  = 1'b1;
        cmd_o.ld_wr = 1'b1;
        state_d     = S_BF_M0;
      end
      S_BF_M0: begin
        cmd_o.ld_b    = 1'b1;
        cmd_o.ld_wi   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RR;
        state_d       = S_BF_M1;
      end
      S_BF_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_II;
        state_d       = S_BF_M2;
      end
      S_BF_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RI;
        state_d       = S_BF_M3;
      end
      S_BF_M3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_IR;
        state_d       = S_BF_T;
      end
      S_BF_T: begin
        cmd_o.ld_t = 1'b1;
        state_d    = S_BF_WH;
      end
      S_BF_WH: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.waddr  = h_idx;
        cmd_o.wsrc   = WSRC_DIFF;
        state_d      = S_BF_WI;
      end
      S_BF_WI: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.waddr  = i_q;
        cmd_o.wsrc   = WSRC_SUM;
        state_d      = S_BF_RH;
        if (i_step < {1'b0, n_len}) begin
          i_d = i_step[IDX_W-1:0];
        end else if (m_inc < l_len) begin
          m_d = m_inc;
          i_d = m_inc[IDX_W-1:0];
        end else if ((st_q + 1'b1) < size_q) begin
          st_d = st_q + 1'b1;
          m_d  = '0;
          i_d  = '0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.out_load  = 1'b1;
        cmd_o.out_kind  = KIND_DONE;
        cmd_o.out_index = '0;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      m_q     <= '0;
      i_q     <= '0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      i_q     <= i_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // Length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // A swap only ever moves an entry to a higher partner
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BR_RA) |-> (rev > m_q[IDX_W-1:0]))
    else $error("bit-reverse swap with lower partner");

  // Upper butterfly operand stays inside the active length
  a_bf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BF_RH) |-> ((IDX_W+1)'(h_idx) < n_len))
    else $error("butterfly index beyond transform length");

  // Finishing a transform posts its done result
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> stat_i.out_valid)
    else $error("done result not posted");
endmodule
